// File: rtl/bdda_pkg.sv
// Shared types, constants and calendar tables for the business-day date adder
package bdda_pkg;

   // field widths of the item payloads
   localparam int DayWidth     = 5;
   localparam int MonthWidth   = 4;
   localparam int YearWidth    = 12;
   localparam int AddDaysWidth = 10;
   localparam int WeekendWidth = 9;

   // absolute year width (relative year plus base)
   localparam int FullYearWidth = 13;
   localparam int OffsetWidth   = 3;

   localparam logic [FullYearWidth-1:0] YearBase = 13'd1900;
   localparam logic [YearWidth-1:0]     YearMax  = 12'd4095;

   // month codes that matter to the calendar logic
   localparam logic [MonthWidth-1:0] MonthJanuary  = 4'd0;
   localparam logic [MonthWidth-1:0] MonthMarch    = 4'd2;
   localparam logic [MonthWidth-1:0] MonthDecember = 4'd11;

   // reciprocal constants for division by 100 on the year and by 7 on the weekday sum
   localparam int Div100Mult  = 5243;
   localparam int Div100Shift = 19;
   localparam int Div7Mult    = 9363;
   localparam int Div7Shift   = 16;
   localparam int Quot100Width = 7;
   localparam int Quot7Width   = 11;

   // weekday correction threshold
   localparam logic [3:0] WeekdayLimit = 4'd5;

   typedef struct packed {
      logic [DayWidth-1:0]     start_day;
      logic [MonthWidth-1:0]   start_month;
      logic [YearWidth-1:0]    start_year;
      logic [AddDaysWidth-1:0] add_days;
   } req_type;

   typedef struct packed {
      logic [DayWidth-1:0]     end_day;
      logic [MonthWidth-1:0]   end_month;
      logic [YearWidth-1:0]    end_year;
      logic [WeekendWidth-1:0] weekend_days;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic calc_year;
      logic calc_div;
      logic calc_sum;
      logic calc_mod;
      logic calc_week;
      logic calc_days;
      logic norm_step;
      logic push;
   } dp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic norm_done;
      logic out_free;
   } dp_status_type;

   // weekday offset per month, zero outside the calendar range
   function automatic logic [OffsetWidth-1:0] wd_offset(input logic [MonthWidth-1:0] m);
      logic [OffsetWidth-1:0] off;
      unique case (m)
         4'd0:    off = 3'd0;
         4'd1:    off = 3'd3;
         4'd2:    off = 3'd2;
         4'd3:    off = 3'd5;
         4'd4:    off = 3'd0;
         4'd5:    off = 3'd3;
         4'd6:    off = 3'd5;
         4'd7:    off = 3'd1;
         4'd8:    off = 3'd4;
         4'd9:    off = 3'd6;
         4'd10:   off = 3'd2;
         4'd11:   off = 3'd4;
         default: off = 3'd0;
      endcase
      return off;
   endfunction

   // days per month, February and invalid months count 28
   function automatic logic [DayWidth-1:0] month_len(input logic [MonthWidth-1:0] m);
      logic [DayWidth-1:0] len;
      unique case (m)
         4'd3, 4'd5, 4'd8, 4'd10:                    len = 5'd30;
         4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
         default:                                    len = 5'd28;
      endcase
      return len;
   endfunction

endpackage

// File: rtl/bdda_ctrl.sv
// Sequencing controller for the business-day date adder
module bdda_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  bdda_pkg::dp_status_type status,
   output bdda_pkg::dp_cmd_type    cmd
);
   import bdda_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_YEAR,
      ST_DIV,
      ST_SUM,
      ST_MOD,
      ST_WEEK,
      ST_DAYS,
      ST_NORM,
      ST_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_YEAR;
         ST_YEAR: state_in = ST_DIV;
         ST_DIV:  state_in = ST_SUM;
         ST_SUM:  state_in = ST_MOD;
         ST_MOD:  state_in = ST_WEEK;
         ST_WEEK: state_in = ST_DAYS;
         ST_DAYS: state_in = ST_NORM;
         ST_NORM: if (status.norm_done) state_in = ST_DONE;
         ST_DONE: if (status.out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // command decode, no item is taken while reset is high
   always_comb begin
      req_ready     = (state_ff == ST_IDLE) && !reset;
      cmd           = '0;
      cmd.load      = req_ready && req_valid;
      cmd.calc_year = (state_ff == ST_YEAR);
      cmd.calc_div  = (state_ff == ST_DIV);
      cmd.calc_sum  = (state_ff == ST_SUM);
      cmd.calc_mod  = (state_ff == ST_MOD);
      cmd.calc_week = (state_ff == ST_WEEK);
      cmd.calc_days = (state_ff == ST_DAYS);
      cmd.norm_step = (state_ff == ST_NORM) && !status.norm_done;
      cmd.push      = (state_ff == ST_DONE) && status.out_free;
   end

endmodule

// File: rtl/bdda_dp.sv
// Datapath: weekday, weekend count, month normalization and output register
module bdda_dp #(
   parameter int ADD_DAYS_WIDTH = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  bdda_pkg::req_type       req_data,
   input  bdda_pkg::dp_cmd_type    cmd,
   output bdda_pkg::dp_status_type status,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output bdda_pkg::rsp_type       rsp_data
);
   import bdda_pkg::*;

   localparam int NW        = ADD_DAYS_WIDTH;
   localparam int AccWidth  = NW + 2;
   localparam int Div5Shift = NW + 2;
   localparam int Div5Mult  = ((1 << Div5Shift) + 4) / 5;
   localparam int P5Width   = 2 * NW + 2;

   // captured item
   logic [DayWidth-1:0]   day_ff;
   logic [MonthWidth-1:0] month_ff, month_in;
   logic [YearWidth-1:0]  year_ff, year_in;
   logic [NW-1:0]         n_ff;

   // weekday intermediates
   logic [FullYearWidth-1:0] yf_ff, yf_in;
   logic [OffsetWidth-1:0]   off_ff;
   logic [Quot100Width-1:0]  q100_ff, q400_ff, q100_in, q400_in;
   logic [NW-1:0]            q5_ff, q5_in;
   logic [FullYearWidth-1:0] sum_ff, sum_in;
   logic [2:0]               r5_ff, r5_in;
   logic [Quot7Width-1:0]    q7_ff, q7_in;
   logic [NW-1:0]            wk_ff, wk_in;
   logic [AccWidth-1:0]      acc_ff, acc_in;

   logic [25:0]              p100, p400;
   logic [P5Width-1:0]       p5;
   logic [NW+2:0]            five_q5;
   logic [26:0]              p7;
   logic [FullYearWidth-1:0] seven_q7;
   logic [2:0]               r7;
   logic [3:0]               rem_sum;
   logic [DayWidth-1:0]      len;
   logic                     over;

   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   // absolute year, less one for January and February
   always_comb begin
      yf_in = FullYearWidth'(year_ff) + YearBase
              - FullYearWidth'(month_ff < MonthMarch);
   end

   // reciprocal multiplies for year/100, year/400 and days/5
   always_comb begin
      p100    = 26'(yf_ff) * 26'(Div100Mult);
      p400    = 26'(yf_ff[FullYearWidth-1:2]) * 26'(Div100Mult);
      q100_in = Quot100Width'(p100 >> Div100Shift);
      q400_in = Quot100Width'(p400 >> Div100Shift);
      p5      = P5Width'(n_ff) * P5Width'(Div5Mult);
      q5_in   = NW'(p5 >> Div5Shift);
   end

   // weekday sum and remainder of days by 5
   always_comb begin
      sum_in  = yf_ff + FullYearWidth'(yf_ff[FullYearWidth-1:2])
                - FullYearWidth'(q100_ff) + FullYearWidth'(q400_ff)
                + FullYearWidth'(off_ff) + FullYearWidth'(day_ff);
      five_q5 = (NW + 3)'(q5_ff) * (NW + 3)'(5);
      r5_in   = 3'((NW + 3)'(n_ff) - five_q5);
   end

   // sum mod 7 by reciprocal, then weekend count
   always_comb begin
      p7       = 27'(sum_ff) * 27'(Div7Mult);
      q7_in    = Quot7Width'(p7 >> Div7Shift);
      seven_q7 = FullYearWidth'(q7_ff) * FullYearWidth'(7);
      r7       = 3'(sum_ff - seven_q7);
      rem_sum  = {1'b0, r5_ff} + {1'b0, r7};
      wk_in    = q5_ff + NW'(rem_sum > WeekdayLimit);
   end

   // day accumulation and one month of normalization
   always_comb begin
      len      = month_len(month_ff);
      over     = acc_ff > AccWidth'(len);
      acc_in   = acc_ff;
      month_in = month_ff;
      year_in  = year_ff;
      if (cmd.calc_days) begin
         acc_in = AccWidth'(day_ff) + AccWidth'(n_ff) + (AccWidth'(wk_ff) << 1);
      end else begin
         acc_in = acc_ff - AccWidth'(len);
         if (month_ff >= MonthDecember) begin
            month_in = MonthJanuary;
            if (year_ff != YearMax) year_in = year_ff + 1'b1;
         end else begin
            month_in = month_ff + 1'b1;
         end
      end
   end

   // result fields
   always_comb begin
      rsp_in.end_day      = DayWidth'(acc_ff);
      rsp_in.end_month    = month_ff;
      rsp_in.end_year     = year_ff;
      rsp_in.weekend_days = WeekendWidth'({wk_ff, 1'b0});
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         day_ff   <= req_data.start_day;
         month_ff <= req_data.start_month;
         year_ff  <= req_data.start_year;
         n_ff     <= NW'(req_data.add_days);
      end else if (cmd.norm_step) begin
         month_ff <= month_in;
         year_ff  <= year_in;
      end
      if (cmd.calc_year) begin
         yf_ff  <= yf_in;
         off_ff <= wd_offset(month_ff);
      end
      if (cmd.calc_div) begin
         q100_ff <= q100_in;
         q400_ff <= q400_in;
         q5_ff   <= q5_in;
      end
      if (cmd.calc_sum) begin
         sum_ff <= sum_in;
         r5_ff  <= r5_in;
      end
      if (cmd.calc_mod) q7_ff <= q7_in;
      if (cmd.calc_week) wk_ff <= wk_in;
      if (cmd.calc_days || cmd.norm_step) acc_ff <= acc_in;
      if (cmd.push) rsp_ff <= rsp_in;
   end

   // output item valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign status.norm_done = !over;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_ff;

endmodule

// File: rtl/business_day_date_adder.sv
// Top level of the business-day date adder
//
// Usage: an item on the req_ channel carries a start date (day, month from 0,
// year from 1900) and a count of business days. The block returns one item on
// the rsp_ channel with the end date and the weekend days inserted.
// Both channels are valid/ready; an item moves when valid and ready are high.
// Timing: after an item is accepted the controller steps through the year,
// divide, sum, mod, week and days states, then normalization walks one
// month per cycle in the datapath across the months crossed (at most about
// 48 for a 10-bit day count) before the result enters the output register.
// Flow: one item at a time; req_ready rises in the same cycle as the result
// enters the output register.
// The output register parts the two sides: a new item is taken while a
// finished result waits. If the receiver stalls, a second result waits in
// the datapath until the output register frees.
// Reset (synchronous, active high) returns the controller to idle and drops
// rsp_valid; req_ready stays low during reset and is high in the first
// cycle after it.
module business_day_date_adder #(
   parameter int ADD_DAYS_WIDTH = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bdda_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bdda_pkg::rsp_type rsp_data
);
   import bdda_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer
   bdda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic and output register
   bdda_dp #(
      .ADD_DAYS_WIDTH (ADD_DAYS_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// File: rtl/bdda_checker.sv
// Port-level checks for the business-day date adder and their binding
module bdda_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input bdda_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input bdda_pkg::rsp_type rsp_data
);
   import bdda_pkg::*;

   // reset leaves the block idle with no result pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_valid && (reset || req_ready)))
      else $error("block not idle after reset");

   // one item at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second item taken while busy");

   // no result can appear right after an accept
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !$rose(rsp_valid))
      else $error("result appeared too early");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed or dropped");

   // waiting input item holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_ready) |=> (req_valid && $stable(req_data)))
      else $error("waiting input item changed or dropped");

endmodule

bind business_day_date_adder bdda_checker u_bdda_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
